// ----- src/dcmr_pkg.sv -----
// Shared widths, reset values and command codes of the DC motor reversal ramp core.
package dcmr_pkg;

	// Field widths.
	localparam int unsigned PWM_W     = 8;
	localparam int unsigned RELAY_W   = 2;
	localparam int unsigned CMD_W     = 2;
	localparam int unsigned STEP_W    = 7;
	localparam int unsigned HOLD_W    = 10;
	localparam int unsigned PERIOD_W  = 10;
	localparam int unsigned WAIT_W    = 16;
	localparam int unsigned TICK_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 16;

	// Register reset values.
	localparam logic [STEP_W-1:0]   STEP_RST   = STEP_W'(5);
	localparam logic [HOLD_W-1:0]   HOLD_RST   = HOLD_W'(10);
	localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(20);
	localparam logic [WAIT_W-1:0]   WAIT_RST   = WAIT_W'(2000);

	// Full-scale PWM compare value.
	localparam logic [PWM_W-1:0] PWM_MAX = '1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPEED_STEP  = 2'd0,
		CFG_ADJUST_HOLD = 2'd1,
		CFG_RAMP_PERIOD = 2'd2,
		CFG_REV_WAIT    = 2'd3
	} cfg_idx_t;

	// Direction commands.
	localparam logic [CMD_W-1:0] DIR_NONE    = 2'd0;
	localparam logic [CMD_W-1:0] DIR_FORWARD = 2'd1;
	localparam logic [CMD_W-1:0] DIR_REVERSE = 2'd2;
	localparam logic [CMD_W-1:0] DIR_STOP    = 2'd3;

	// Speed buttons.
	localparam logic [CMD_W-1:0] BTN_FASTER = 2'd1;
	localparam logic [CMD_W-1:0] BTN_SLOWER = 2'd2;

	// Relay drive codes.
	localparam logic [RELAY_W-1:0] RELAY_STOPPED = 2'd0;
	localparam logic [RELAY_W-1:0] RELAY_FORWARD = 2'd1;
	localparam logic [RELAY_W-1:0] RELAY_REVERSE = 2'd2;

	// One result.
	typedef struct packed {
		logic [PWM_W-1:0]   pwm;
		logic [RELAY_W-1:0] relay;
		logic               busy;
	} res_t;

endpackage

// ----- src/dc_motor_reversal_soft_ramp_core.sv -----
// DC motor speed and direction controller with soft PWM ramp and safe relay reversal.
//
// Each tick request gives one result, and a new tick can be taken in every
// cycle while in_stall is low. The controller state updates directly from the
// accepted request, and the result goes into an output register backed by one skid
// entry, so in_stall rises only when both already hold results that out_stall keeps
// from leaving. While idle, a speed button moves the PWM compare by speed_step
// (saturating at 0 and 255) and starts a nonzero adjust hold; a direction command
// ramps the PWM down one unit per ramp period, switches the relay, waits the reversal
// time and ramps back up to the saved speed. Requests during a sequence are ignored.
module dc_motor_reversal_soft_ramp_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// Tick request channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dcmr_pkg::CMD_W-1:0]     direction_cmd,
	input  logic [dcmr_pkg::CMD_W-1:0]     speed_button,
	// Result channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dcmr_pkg::PWM_W-1:0]     pwm_compare,
	output logic [dcmr_pkg::RELAY_W-1:0]   relay_code,
	output logic                           busy_res,
	// Configuration write port.
	input  logic                           cfg_we,
	input  logic [dcmr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dcmr_pkg::CFG_W-1:0]     cfg_data
);
	import dcmr_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_HOLD = 3'd1,
		PH_DOWN = 3'd2,
		PH_WAIT = 3'd3,
		PH_UP   = 3'd4
	} phase_t;

	// Configuration registers.
	logic [STEP_W-1:0]   step_q;
	logic [HOLD_W-1:0]   hold_q;
	logic [PERIOD_W-1:0] period_q;
	logic [WAIT_W-1:0]   wait_q;

	// Controller state.
	phase_t             phase_q, phase_d;
	logic [PWM_W-1:0]   pwm_q, pwm_d;
	logic [PWM_W-1:0]   saved_q, saved_d;
	logic [RELAY_W-1:0] relay_q, relay_d;
	logic [RELAY_W-1:0] pend_q, pend_d;
	logic [TICK_W-1:0]  tick_q, tick_d;

	// Output register and skid entry.
	logic out_valid_q, skid_valid_q;
	res_t out_q, skid_q, res_d;

	logic              in_acc, out_acc;
	logic [TICK_W-1:0] tick_inc, tick_dec;
	logic              ramp_hit;
	logic [PWM_W:0]    sum_up;
	logic [PWM_W-1:0]  step_ext;

	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_RST;
			hold_q   <= HOLD_RST;
			period_q <= PERIOD_RST;
			wait_q   <= WAIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SPEED_STEP:  step_q   <= cfg_data[STEP_W-1:0];
				CFG_ADJUST_HOLD: hold_q   <= cfg_data[HOLD_W-1:0];
				CFG_RAMP_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				CFG_REV_WAIT:    wait_q   <= cfg_data[WAIT_W-1:0];
				default:         ;
			endcase
		end
	end

	// Shared arithmetic for the tick counter and the speed adjust.
	assign tick_inc = tick_q + TICK_W'(1);
	assign tick_dec = (tick_q != '0) ? tick_q - TICK_W'(1) : tick_q;
	assign ramp_hit = tick_inc >= TICK_W'(period_q);
	assign step_ext = PWM_W'(step_q);
	assign sum_up   = {1'b0, pwm_q} + {1'b0, step_ext};

	// Next state for one tick.
	always_comb begin
		phase_d = phase_q;
		pwm_d   = pwm_q;
		saved_d = saved_q;
		relay_d = relay_q;
		pend_d  = pend_q;
		tick_d  = tick_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (direction_cmd != DIR_NONE) begin
					saved_d = pwm_q;
					pend_d  = (direction_cmd == DIR_FORWARD) ? RELAY_FORWARD :
						(direction_cmd == DIR_REVERSE) ? RELAY_REVERSE : RELAY_STOPPED;
					tick_d  = '0;
					phase_d = PH_DOWN;
				end else if (speed_button == BTN_FASTER && pwm_q != PWM_MAX) begin
					pwm_d = sum_up[PWM_W] ? PWM_MAX : sum_up[PWM_W-1:0];
					if (hold_q != '0) begin
						phase_d = PH_HOLD;
						tick_d  = TICK_W'(hold_q);
					end
				end else if (speed_button == BTN_SLOWER && pwm_q != '0) begin
					pwm_d = (pwm_q > step_ext) ? pwm_q - step_ext : '0;
					if (hold_q != '0) begin
						phase_d = PH_HOLD;
						tick_d  = TICK_W'(hold_q);
					end
				end
			end
			PH_HOLD: begin
				tick_d = tick_dec;
				if (tick_dec == '0) begin
					phase_d = PH_IDLE;
				end
			end
			PH_DOWN: begin
				if (pwm_q == '0) begin
					relay_d = pend_q;
					tick_d  = wait_q;
					phase_d = PH_WAIT;
				end else if (ramp_hit) begin
					tick_d = '0;
					pwm_d  = pwm_q - PWM_W'(1);
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_WAIT: begin
				if (tick_q == '0) begin
					phase_d = PH_UP;
				end else begin
					tick_d = tick_dec;
				end
			end
			PH_UP: begin
				if (pwm_q >= saved_q) begin
					phase_d = PH_IDLE;
					tick_d  = '0;
				end else if (ramp_hit) begin
					tick_d = '0;
					pwm_d  = pwm_q + PWM_W'(1);
				end else begin
					tick_d = tick_inc;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				tick_d  = '0;
			end
		endcase
		res_d.pwm   = pwm_d;
		res_d.relay = relay_d;
		res_d.busy  = (phase_d != PH_IDLE);
	end

	// State update on each accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pwm_q   <= '0;
			saved_q <= '0;
			relay_q <= RELAY_STOPPED;
			pend_q  <= RELAY_STOPPED;
			tick_q  <= '0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			pwm_q   <= pwm_d;
			saved_q <= saved_d;
			relay_q <= relay_d;
			pend_q  <= pend_d;
			tick_q  <= tick_d;
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_acc) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= in_acc;
				end
			end else if (in_acc) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_acc) begin
			out_q <= skid_valid_q ? skid_q : res_d;
		end
		if (in_acc && out_valid_q && !out_acc) begin
			skid_q <= res_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign pwm_compare = out_q.pwm;
	assign relay_code  = out_q.relay;
	assign busy_res    = out_q.busy;

	// The skid entry is only ever filled behind a full output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	// An adjust hold always has ticks left to count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HOLD) |-> (tick_q != '0))
		else $error("adjust hold running with a zero tick count");

	// The ramp up never passes the saved speed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_UP) |-> (pwm_q <= saved_q))
		else $error("ramp up exceeded the saved speed");

	// The relay only switches when leaving the ramp down at zero speed.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(relay_q) |-> ($past(phase_q) == PH_DOWN && $past(pwm_q) == '0))
		else $error("relay switched outside the zero-speed point of a sequence");

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the DC motor reversal soft ramp core.
module testbench;
	import dcmr_pkg::*;

	// Button codes that the package does not name.
	localparam logic [CMD_W-1:0] BTN_IDLE   = 2'd0;
	localparam logic [CMD_W-1:0] BTN_UNUSED = 2'd3;

	// Cycles with no request moving on any port before the run is abandoned.
	localparam int unsigned QUIET_LIMIT = 2000;

	// Phases of the controller as the predictor tracks them.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HOLD,
		ST_DOWN,
		ST_WAIT,
		ST_UP
	} ctl_state_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [CMD_W-1:0]     direction_cmd;
	logic [CMD_W-1:0]     speed_button;
	logic                 out_valid;
	logic                 out_stall;
	logic [PWM_W-1:0]     pwm_compare;
	logic [RELAY_W-1:0]   relay_code;
	logic                 busy_res;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	dc_motor_reversal_soft_ramp_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.direction_cmd (direction_cmd),
		.speed_button  (speed_button),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pwm_compare   (pwm_compare),
		.relay_code    (relay_code),
		.busy_res      (busy_res),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Predicted controller registers.
	logic [STEP_W-1:0]   step_reg;
	logic [HOLD_W-1:0]   hold_reg;
	logic [PERIOD_W-1:0] period_reg;
	logic [WAIT_W-1:0]   wait_reg;
	logic [PWM_W-1:0]    pwm_now;
	logic [PWM_W-1:0]    saved_pwm;
	logic [RELAY_W-1:0]  relay_now;
	logic [RELAY_W-1:0]  relay_target;
	ctl_state_t          ctl_state;
	logic [TICK_W-1:0]   ctl_ticks;

	// Motor outputs expected for each accepted tick, oldest first.
	res_t expected_ticks[$];

	int gap_pct = 24;
	int stall_pct = 24;
	int fail_count = 0;
	int ticks_sent = 0;
	int commands_taken = 0;
	int results_seen = 0;
	int settings_used = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Puts the predictor in its post-reset state.
	function automatic void reset_controller();
		step_reg     = STEP_RST;
		hold_reg     = HOLD_RST;
		period_reg   = PERIOD_RST;
		wait_reg     = WAIT_RST;
		pwm_now      = '0;
		saved_pwm    = '0;
		relay_now    = RELAY_STOPPED;
		relay_target = RELAY_STOPPED;
		ctl_state    = ST_IDLE;
		ctl_ticks    = '0;
	endfunction

	// Counts one ramp tick and tells whether a whole period has gone by.
	function automatic bit ramp_due();
		ctl_ticks = ctl_ticks + TICK_W'(1);
		if (ctl_ticks >= TICK_W'(period_reg)) begin
			ctl_ticks = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// An adjust holds off further input unless the hold time is zero.
	function automatic void begin_hold();
		if (hold_reg != '0) begin
			ctl_state = ST_HOLD;
			ctl_ticks = TICK_W'(hold_reg);
		end
	endfunction

	// Advances the controller by one tick and returns the outputs after it.
	function automatic res_t advance_controller(logic [CMD_W-1:0] dir, logic [CMD_W-1:0] btn);
		logic [PWM_W:0] sum;
		res_t r;
		case (ctl_state)
			ST_IDLE: begin
				if (dir != DIR_NONE) begin
					saved_pwm    = pwm_now;
					relay_target = (dir == DIR_STOP) ? RELAY_STOPPED : dir;
					ctl_ticks    = '0;
					ctl_state    = ST_DOWN;
				end else if (btn == BTN_FASTER) begin
					if (pwm_now != PWM_MAX) begin
						sum = {1'b0, pwm_now} + (PWM_W+1)'(step_reg);
						pwm_now = (sum > {1'b0, PWM_MAX}) ? PWM_MAX : sum[PWM_W-1:0];
						begin_hold();
					end
				end else if (btn == BTN_SLOWER) begin
					if (pwm_now != '0) begin
						pwm_now = (pwm_now > PWM_W'(step_reg)) ?
							pwm_now - PWM_W'(step_reg) : '0;
						begin_hold();
					end
				end
			end
			ST_HOLD: begin
				if (ctl_ticks != '0)
					ctl_ticks = ctl_ticks - TICK_W'(1);
				if (ctl_ticks == '0)
					ctl_state = ST_IDLE;
			end
			ST_DOWN: begin
				if (pwm_now == '0) begin
					relay_now = relay_target;
					ctl_ticks = wait_reg;
					ctl_state = ST_WAIT;
				end else if (ramp_due()) begin
					pwm_now = pwm_now - PWM_W'(1);
				end
			end
			ST_WAIT: begin
				if (ctl_ticks == '0)
					ctl_state = ST_UP;
				else
					ctl_ticks = ctl_ticks - TICK_W'(1);
			end
			ST_UP: begin
				if (pwm_now >= saved_pwm) begin
					ctl_state = ST_IDLE;
					ctl_ticks = '0;
				end else if (ramp_due()) begin
					pwm_now = pwm_now + PWM_W'(1);
				end
			end
			default: begin
				ctl_state = ST_IDLE;
				ctl_ticks = '0;
			end
		endcase
		r.pwm   = pwm_now;
		r.relay = relay_now;
		r.busy  = (ctl_state != ST_IDLE);
		return r;
	endfunction

	// Offers one tick request, waits until it is taken and records its outcome.
	task automatic send_tick(input logic [CMD_W-1:0] dir, input logic [CMD_W-1:0] btn);
		bit was_idle;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		direction_cmd <= dir;
		speed_button  <= btn;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		was_idle = (ctl_state == ST_IDLE);
		expected_ticks.push_back(advance_controller(dir, btn));
		ticks_sent++;
		if (was_idle && (dir != DIR_NONE || btn == BTN_FASTER || btn == BTN_SLOWER))
			commands_taken++;
	endtask

	// Feeds noise until the controller is idle, then lets every result drain.
	task automatic settle();
		while (ctl_state != ST_IDLE)
			send_tick(CMD_W'($urandom_range(3)), CMD_W'($urandom_range(3)));
		in_valid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes one register; the caller lowers the write enable afterwards.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			CFG_SPEED_STEP:  step_reg   = val[STEP_W-1:0];
			CFG_ADJUST_HOLD: hold_reg   = val[HOLD_W-1:0];
			CFG_RAMP_PERIOD: period_reg = val[PERIOD_W-1:0];
			CFG_REV_WAIT:    wait_reg   = val[WAIT_W-1:0];
			default: ;
		endcase
	endtask

	// Loads all four registers once the block has gone quiet.
	task automatic set_config(input int step, input int hold, input int period,
			input int rev_wait);
		settle();
		write_reg(CFG_SPEED_STEP, CFG_W'(step));
		write_reg(CFG_ADJUST_HOLD, CFG_W'(hold));
		write_reg(CFG_RAMP_PERIOD, CFG_W'(period));
		write_reg(CFG_REV_WAIT, CFG_W'(rev_wait));
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Reset values: adjusts up and down with the default step and hold.
	task automatic test_reset_values();
		send_tick(DIR_NONE, BTN_IDLE);
		send_tick(DIR_NONE, BTN_FASTER);
		settle();
		send_tick(DIR_NONE, BTN_SLOWER);
		settle();
	endtask

	// Largest step with no hold: saturation at both ends and the unused code.
	task automatic test_speed_limits();
		set_config(127, 0, 1, 0);
		repeat (4) send_tick(DIR_NONE, BTN_FASTER);
		send_tick(DIR_NONE, BTN_UNUSED);
		repeat (4) send_tick(DIR_NONE, BTN_SLOWER);
		// A zero step still starts the hold.
		set_config(0, 3, 1, 0);
		send_tick(DIR_NONE, BTN_FASTER);
		settle();
		send_tick(DIR_NONE, BTN_SLOWER);
		// A long hold.
		set_config(1, 40, 1, 0);
		send_tick(DIR_NONE, BTN_FASTER);
		settle();
	endtask

	// Direction beats a button on the same tick; reverse, stop and forward.
	task automatic test_priority();
		set_config(10, 2, 0, 0);
		send_tick(DIR_NONE, BTN_FASTER);
		settle();
		send_tick(DIR_REVERSE, BTN_FASTER);
		settle();
		send_tick(DIR_STOP, BTN_SLOWER);
		settle();
		send_tick(DIR_FORWARD, BTN_IDLE);
		settle();
	endtask

	// Reversal from standstill with a long wait, then a long ramp period.
	task automatic test_zero_speed_reversal();
		set_config(127, 0, 1, 0);
		while (pwm_now != '0)
			send_tick(DIR_NONE, BTN_SLOWER);
		set_config(2, 0, 15, 60);
		send_tick(DIR_REVERSE, BTN_IDLE);
		settle();
		set_config(2, 0, 15, 0);
		send_tick(DIR_NONE, BTN_FASTER);
		send_tick(DIR_FORWARD, BTN_IDLE);
		settle();
	endtask

	// Random commands under random settings; one round runs with no idling at all.
	task automatic test_random_traffic();
		int goal;
		int pick;
		for (int round = 0; round < 4; round++) begin
			set_config($urandom_range(0, 127), $urandom_range(0, 12),
				$urandom_range(0, 2), $urandom_range(0, 8));
			if (round == 2) begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			goal = ticks_sent + ((round == 2) ? 80 : 40);
			while (ticks_sent < goal) begin
				pick = $urandom_range(99);
				if (ctl_state != ST_IDLE)
					send_tick(CMD_W'($urandom_range(3)), CMD_W'($urandom_range(3)));
				else if (pick < 10 && pwm_now < PWM_W'(16))
					send_tick(CMD_W'($urandom_range(1, 3)), CMD_W'($urandom_range(3)));
				else if (pick < 16)
					send_tick(DIR_NONE, $urandom_range(1) ? BTN_UNUSED : BTN_IDLE);
				else if (pick < 60)
					send_tick(DIR_NONE, BTN_FASTER);
				else
					send_tick(DIR_NONE, BTN_SLOWER);
			end
			gap_pct   = 24;
			stall_pct = 24;
		end
	endtask

	// Result side stalls at random.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_ticks.size() == 0) begin
				fail_count++;
				$display("%0t: result with none expected: pwm %0d relay %0d busy %0b",
					$time, pwm_compare, relay_code, busy_res);
			end else begin
				want = expected_ticks.pop_front();
				if (pwm_compare !== want.pwm) begin
					fail_count++;
					$display("%0t: pwm_compare expected %0d, got %0d",
						$time, want.pwm, pwm_compare);
				end
				if (relay_code !== want.relay) begin
					fail_count++;
					$display("%0t: relay_code expected %0d, got %0d",
						$time, want.relay, relay_code);
				end
				if (busy_res !== want.busy) begin
					fail_count++;
					$display("%0t: busy_res expected %0b, got %0b",
						$time, want.busy, busy_res);
				end
			end
		end
	end

	// Ends the run when nothing has moved for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
				$display("dc_motor_reversal_soft_ramp_core: mismatch");
				$finish;
			end
		end
	end

	// Reset, then the tests in turn.
	initial begin
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		direction_cmd <= DIR_NONE;
		speed_button  <= BTN_IDLE;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_SPEED_STEP;
		cfg_data      <= '0;
		reset_controller();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_speed_limits();
		test_priority();
		test_zero_speed_reversal();
		test_random_traffic();
		settle();

		$display("Sent %0d tick requests, %0d of them acted on as commands.",
			ticks_sent, commands_taken);
		$display("Checked %0d results across %0d register settings plus the reset values.",
			results_seen, settings_used);
		if (fail_count == 0)
			$display("dc_motor_reversal_soft_ramp_core: match");
		else
			$display("dc_motor_reversal_soft_ramp_core: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
src/dcmr_pkg.sv
src/dc_motor_reversal_soft_ramp_core.sv
bench/testbench.sv
